[rtl/clns_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// clns_pkg: shared types and constants of the character lcd nibble sequencer
// request and result item layouts, request codes, register indexes and the
// segment table of the init program
// ----------------------------------------------------------------------------
package clns_pkg;

	// request kinds
	localparam logic [2:0] FUNC_INIT  = 3'd0;
	localparam logic [2:0] FUNC_CMD   = 3'd1;
	localparam logic [2:0] FUNC_DATA  = 3'd2;
	localparam logic [2:0] FUNC_GOTO  = 3'd3;
	localparam logic [2:0] FUNC_CLEAR = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_LINE2_BASE = 2'd0;
	localparam logic [1:0] REG_LINE3_BASE = 2'd1;
	localparam logic [1:0] REG_LINE4_BASE = 2'd2;

	localparam logic [6:0] LINE2_BASE_RST = 7'd64;
	localparam logic [6:0] LINE3_BASE_RST = 7'd20;
	localparam logic [6:0] LINE4_BASE_RST = 7'd84;

	// hold times in microseconds
	localparam logic [13:0] HOLD_POWER_UP = 14'd16000;
	localparam logic [13:0] HOLD_WAKE     = 14'd5000;
	localparam logic [13:0] HOLD_FOUR_BIT = 14'd90;
	localparam logic [13:0] HOLD_CMD      = 14'd240;
	localparam logic [13:0] HOLD_DATA     = 14'd50;
	localparam logic [13:0] HOLD_HOME     = 14'd2240;
	localparam logic [13:0] HOLD_CLEAR    = 14'd3240;
	localparam logic [13:0] HOLD_STROBE   = 14'd1;

	// lcd instruction bytes
	localparam logic [7:0] LCD_WAKE      = 8'h30;
	localparam logic [7:0] LCD_FOUR_BIT  = 8'h20;
	localparam logic [7:0] LCD_FUNC_SET  = 8'h28;
	localparam logic [7:0] LCD_DISP_OFF  = 8'h08;
	localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
	localparam logic [7:0] LCD_ENTRY     = 8'h06;
	localparam logic [7:0] LCD_CLR_DISP  = 8'h01;
	localparam logic [7:0] LCD_SET_DDRAM = 8'h80;

	localparam logic [3:0] INIT_LAST_SEG = 4'd9;
	localparam logic [3:0] NIB_LAST_SUB  = 4'd3;
	localparam logic [3:0] BYTE_LAST_SUB = 4'd8;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] value;
		logic [6:0] column;
		logic [3:0] row;
		logic [1:0] display_sel;
	} req_t;

	typedef struct packed {
		logic [7:0]  pins;
		logic [13:0] hold_us;
		logic        last;
	} rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef enum logic [1:0] {
		SEG_SINGLE,
		SEG_NIBBLE,
		SEG_BYTE
	} seg_kind_t;

	typedef struct packed {
		seg_kind_t   kind;
		logic [7:0]  val;
		logic [13:0] tail;
		logic        last;
	} seg_info_t;

	// init program: power-up wait, three wake nibbles, switch to four bits, five bytes
	function automatic seg_info_t init_seg(input logic [3:0] seg);
		seg_info_t s;
		s.last = 1'b0;
		case (seg)
			4'd0: s = '{SEG_SINGLE, 8'h00, HOLD_POWER_UP, 1'b0};
			4'd1: s = '{SEG_NIBBLE, LCD_WAKE, HOLD_WAKE, 1'b0};
			4'd2: s = '{SEG_NIBBLE, LCD_WAKE, HOLD_WAKE, 1'b0};
			4'd3: s = '{SEG_NIBBLE, LCD_WAKE, HOLD_WAKE, 1'b0};
			4'd4: s = '{SEG_NIBBLE, LCD_FOUR_BIT, HOLD_FOUR_BIT, 1'b0};
			4'd5: s = '{SEG_BYTE, LCD_FUNC_SET, HOLD_CMD, 1'b0};
			4'd6: s = '{SEG_BYTE, LCD_DISP_OFF, HOLD_CMD, 1'b0};
			4'd7: s = '{SEG_BYTE, LCD_DISP_ON, HOLD_HOME, 1'b0};
			4'd8: s = '{SEG_BYTE, LCD_ENTRY, HOLD_HOME, 1'b0};
			4'd9: s = '{SEG_BYTE, LCD_CLR_DISP, HOLD_CLEAR, 1'b1};
			default: s = '{SEG_BYTE, LCD_CLR_DISP, HOLD_CLEAR, 1'b1};
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

[rtl/char_lcd_nibble_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer: 4-bit bus character lcd request sequencer
// expands init, command, data, goto and clear requests into timed pin states
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  req       in         req_valid / req_ready  clns_pkg::req_t
//  rsp       out        rsp_valid / rsp_ready  clns_pkg::rsp_t
//  cfg       in         cfg_wr_en              cfg_index, cfg_data
//
// one pin state leaves per cycle while the result side keeps taking them;
// a request gives 9 pin states, or 62 for init, and the step sequencer
// (segment and sub-step counters) walks through them. req_ready is low
// while a request is being expanded. unknown request kinds are taken and
// give no states. a stalled result holds the sequencer; reset clears the
// sequencer and loads the line bases.
//
module char_lcd_nibble_sequencer (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire clns_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output clns_pkg::rsp_t       rsp,
	input  wire logic            cfg_wr_en,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [6:0]      cfg_data
);

	clns_pkg::state_t state_q, state_d;
	logic [6:0] line2_q, line3_q, line4_q;
	logic [2:0] func_q;
	logic [7:0] byte_q;
	logic       rs_q;
	logic [2:0] en_q;
	logic [3:0] seg_q, seg_d;
	logic [3:0] sub_q, sub_d;
	logic       out_valid_q;
	clns_pkg::rsp_t out_q;

	logic            accept;
	logic            step;
	logic            seg_end;
	clns_pkg::seg_info_t seg;
	clns_pkg::rsp_t  nxt;
	logic [6:0]      base_sel;
	logic [6:0]      addr;
	logic [3:0]      k;
	logic [1:0]      phase;
	logic [3:0]      nib;
	logic [13:0]     tail_req;

	assign req_ready = (state_q == clns_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign step      = (state_q == clns_pkg::ST_RUN) && (!out_valid_q || rsp_ready);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line2_q <= clns_pkg::LINE2_BASE_RST;
			line3_q <= clns_pkg::LINE3_BASE_RST;
			line4_q <= clns_pkg::LINE4_BASE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				clns_pkg::REG_LINE2_BASE: line2_q <= cfg_data;
				clns_pkg::REG_LINE3_BASE: line3_q <= cfg_data;
				clns_pkg::REG_LINE4_BASE: line4_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// cursor address: line base plus column minus one, modulo 128
	always_comb begin
		case (req.row)
			4'd2:    base_sel = line2_q;
			4'd3:    base_sel = line3_q;
			4'd4:    base_sel = line4_q;
			default: base_sel = 7'd0;
		endcase
		addr = base_sel + req.column - 7'd1;
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			rs_q   <= (req.func == clns_pkg::FUNC_DATA);
			case (req.display_sel)
				2'd1:    en_q <= 3'b010;
				2'd2:    en_q <= 3'b100;
				default: en_q <= 3'b001;
			endcase
			case (req.func)
				clns_pkg::FUNC_GOTO:  byte_q <= clns_pkg::LCD_SET_DDRAM | {1'b0, addr};
				clns_pkg::FUNC_CLEAR: byte_q <= clns_pkg::LCD_CLR_DISP;
				default:              byte_q <= req.value;
			endcase
		end
	end

	// segment description for the current step
	always_comb begin
		case (func_q)
			clns_pkg::FUNC_DATA:  tail_req = clns_pkg::HOLD_DATA;
			clns_pkg::FUNC_CLEAR: tail_req = clns_pkg::HOLD_CLEAR;
			default:              tail_req = clns_pkg::HOLD_CMD;
		endcase
		if (func_q == clns_pkg::FUNC_INIT) begin
			seg = clns_pkg::init_seg(seg_q);
		end else begin
			seg = '{clns_pkg::SEG_BYTE, byte_q, tail_req, 1'b1};
		end
	end

	// pin state of the current step
	always_comb begin
		k       = sub_q;
		seg_end = 1'b0;
		nxt     = '{8'h00, clns_pkg::HOLD_STROBE, 1'b0};
		case (seg.kind)
			clns_pkg::SEG_SINGLE: begin
				seg_end     = 1'b1;
				nxt.pins    = 8'h00;
				nxt.hold_us = seg.tail;
			end
			clns_pkg::SEG_NIBBLE: begin
				seg_end = (sub_q == clns_pkg::NIB_LAST_SUB);
				k       = sub_q;
			end
			clns_pkg::SEG_BYTE: begin
				seg_end = (sub_q == clns_pkg::BYTE_LAST_SUB);
				k       = sub_q - 4'd1;
			end
			default: ;
		endcase
		phase = k[1:0];
		nib   = (seg.kind == clns_pkg::SEG_BYTE && k[2]) ? seg.val[3:0] : seg.val[7:4];
		if (seg.kind != clns_pkg::SEG_SINGLE) begin
			if (seg.kind == clns_pkg::SEG_BYTE && sub_q == 4'd0) begin
				// set-up state with select only
				nxt.pins    = {7'd0, rs_q};
				nxt.hold_us = clns_pkg::HOLD_STROBE;
			end else begin
				case (phase)
					2'd1:    nxt.pins = {nib, en_q, rs_q};
					2'd3:    nxt.pins = {nib, 4'b0000};
					default: nxt.pins = {nib, 3'b000, rs_q};
				endcase
				if (phase == 2'd3) begin
					nxt.hold_us = seg_end ? seg.tail : 14'd0;
				end
			end
		end
		nxt.last = seg_end && seg.last;
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clns_pkg::ST_IDLE;
			seg_q   <= 4'd0;
			sub_q   <= 4'd0;
		end else begin
			state_q <= state_d;
			seg_q   <= seg_d;
			sub_q   <= sub_d;
		end
	end

	// next state and step counters
	always_comb begin
		state_d = state_q;
		seg_d   = seg_q;
		sub_d   = sub_q;
		case (state_q)
			clns_pkg::ST_IDLE: begin
				if (accept && req.func <= clns_pkg::FUNC_CLEAR) begin
					state_d = clns_pkg::ST_RUN;
					seg_d   = 4'd0;
					sub_d   = 4'd0;
				end
			end
			clns_pkg::ST_RUN: begin
				if (step) begin
					if (seg_end) begin
						sub_d = 4'd0;
						if (seg.last) begin
							state_d = clns_pkg::ST_IDLE;
						end else begin
							seg_d = seg_q + 4'd1;
						end
					end else begin
						sub_d = sub_q + 4'd1;
					end
				end
			end
			default: state_d = clns_pkg::ST_IDLE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= nxt;
		end
	end

endmodule
`default_nettype wire

[rtl/clns_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// clns_checker: port-level checks of the character lcd nibble sequencer
// watches the request, result and configuration ports over time
// ----------------------------------------------------------------------------
module clns_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            req_valid,
	input wire logic            req_ready,
	input wire clns_pkg::req_t  req,
	input wire logic            rsp_valid,
	input wire logic            rsp_ready,
	input wire clns_pkg::rsp_t  rsp,
	input wire logic            cfg_wr_en,
	input wire logic [1:0]      cfg_index,
	input wire logic [6:0]      cfg_data
);

	// a known request kind keeps the block busy in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.func <= clns_pkg::FUNC_CLEAR |=> !req_ready)
		else $error("request taken without going busy");

	// while idle, a pending result can only be the final state of a request
	assert property (@(posedge clk) disable iff (!arst_n)
		req_ready && rsp_valid |-> rsp.last)
		else $error("idle with a non-final item pending");

	// an enable strobe is held for exactly one microsecond
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.pins[3:1] != 3'b000 |-> rsp.hold_us == clns_pkg::HOLD_STROBE)
		else $error("enable strobe with wrong hold");

	// a stalled result item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result item changed");

	// line bases are written only while idle with nothing pending
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |-> req_ready && !rsp_valid &&
			cfg_index <= clns_pkg::REG_LINE4_BASE && !$isunknown(cfg_data))
		else $error("configuration written while busy");

endmodule

bind char_lcd_nibble_sequencer clns_checker u_clns_checker (.*);
`default_nettype wire
